>>> design/assert_macros.svh
// Assertion macros shared by the decoder modules.
// Needs a clock named clock and a reset named reset in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold on every clock edge outside reset.
`define U8_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Expression must never be true outside reset.
`define U8_NEVER(label, expr, msg) \
   `U8_ASSERT(label, !(expr), msg)

`endif

>>> design/u8dec_pkg.sv
// Shared types and constants for the UTF-8 to UCS-2 stream decoder.
// No dependencies.
package u8dec_pkg;

   // decode phase of the front end
   typedef enum logic [2:0] {
      PH_READY   = 3'd0,
      PH_TWO_B   = 3'd1,
      PH_THREE_B = 3'd2,
      PH_THREE_C = 3'd3,
      PH_DISCARD = 3'd4
   } phase_type;

   // kind of work handed from front to back
   typedef enum logic [1:0] {
      CMD_UNIT     = 2'd0,
      CMD_ELLIPSIS = 2'd1,
      CMD_BAD_LEAD = 2'd2
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [15:0]  unit;
      logic         eos;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int STEP_W = 2;
   localparam logic [STEP_W-1:0] ELLIPSIS_LAST_STEP = 2'd2;
   localparam logic [STEP_W-1:0] BAD_LEAD_LAST_STEP = 2'd1;

   localparam logic [7:0] BYTE_ZERO     = 8'h00;
   localparam logic [7:0] BYTE_ELLIPSIS = 8'h85;
   localparam logic [7:0] MASK_CONT     = 8'hC0;
   localparam logic [7:0] CONT_TAG      = 8'h80;
   localparam logic [7:0] MASK_LEAD2    = 8'hE0;
   localparam logic [7:0] LEAD2_TAG     = 8'hC0;
   localparam logic [7:0] MASK_LEAD3    = 8'hF0;
   localparam logic [7:0] LEAD3_TAG     = 8'hE0;
   localparam logic [7:0] PAY_LEAD2     = 8'h1F;
   localparam logic [7:0] PAY_LEAD3     = 8'h0F;
   localparam logic [7:0] PAY_CONT      = 8'h3F;

   localparam logic [15:0] UNIT_TERM     = 16'h0000;
   localparam logic [15:0] UNIT_PERIOD   = 16'h002E;
   localparam logic [15:0] UNIT_QUESTION = 16'h003F;

endpackage

>>> design/u8dec_front.sv
// Front end: accepts bytes, tracks the UTF-8 phase, issues commands.
// Depends on u8dec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8dec_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  logic [7:0]         req_in_byte,
   input  logic               q_full,
   output logic               cmd_push,
   output u8dec_pkg::cmd_type cmd
);
   import u8dec_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [15:0] partial_ff, partial_in;
   logic        accept;
   logic        cont_ok;
   logic        is_zero;
   logic        cmd_valid;

   assign accept   = push && !q_full;
   assign cont_ok  = (req_in_byte & MASK_CONT) == CONT_TAG;
   assign is_zero  = req_in_byte == BYTE_ZERO;
   assign cmd_push = accept && cmd_valid;

   // next state
   always_comb begin
      phase_in   = phase_ff;
      partial_in = partial_ff;
      unique case (phase_ff)
         PH_TWO_B, PH_THREE_C: begin
            partial_in = '0;
            if (cont_ok || is_zero) phase_in = PH_READY;
            else phase_in = PH_DISCARD;
         end
         PH_THREE_B: begin
            if (cont_ok) begin
               partial_in = partial_ff | (16'(req_in_byte & PAY_CONT) << 6);
               phase_in   = PH_THREE_C;
            end else begin
               partial_in = '0;
               phase_in   = is_zero ? PH_READY : PH_DISCARD;
            end
         end
         PH_DISCARD: begin
            if (is_zero) phase_in = PH_READY;
         end
         default: begin
            partial_in = '0;
            phase_in   = PH_READY;
            priority if (is_zero || !req_in_byte[7]) begin
               phase_in = PH_READY;
            end else if ((req_in_byte & MASK_LEAD2) == LEAD2_TAG) begin
               partial_in = 16'(req_in_byte & PAY_LEAD2) << 6;
               phase_in   = PH_TWO_B;
            end else if ((req_in_byte & MASK_LEAD3) == LEAD3_TAG) begin
               partial_in = 16'(req_in_byte & PAY_LEAD3) << 12;
               phase_in   = PH_THREE_B;
            end else if (req_in_byte == BYTE_ELLIPSIS) begin
               phase_in = PH_READY;
            end else begin
               phase_in = PH_DISCARD;
            end
         end
      endcase
   end

   // command output
   always_comb begin
      cmd_valid = 1'b0;
      cmd.kind  = CMD_UNIT;
      cmd.unit  = UNIT_TERM;
      cmd.eos   = 1'b0;
      unique case (phase_ff)
         PH_TWO_B, PH_THREE_C: begin
            cmd_valid = 1'b1;
            if (cont_ok) cmd.unit = partial_ff | 16'(req_in_byte & PAY_CONT);
            else cmd.eos = 1'b1;
         end
         PH_THREE_B: begin
            if (!cont_ok) begin
               cmd_valid = 1'b1;
               cmd.eos   = 1'b1;
            end
         end
         PH_DISCARD: begin
            cmd_valid = 1'b0;
         end
         default: begin
            priority if (is_zero) begin
               cmd_valid = 1'b1;
               cmd.eos   = 1'b1;
            end else if (!req_in_byte[7]) begin
               cmd_valid = 1'b1;
               cmd.unit  = 16'(req_in_byte);
            end else if ((req_in_byte & MASK_LEAD2) == LEAD2_TAG) begin
               cmd_valid = 1'b0;
            end else if ((req_in_byte & MASK_LEAD3) == LEAD3_TAG) begin
               cmd_valid = 1'b0;
            end else if (req_in_byte == BYTE_ELLIPSIS) begin
               cmd_valid = 1'b1;
               cmd.kind  = CMD_ELLIPSIS;
            end else begin
               cmd_valid = 1'b1;
               cmd.kind  = CMD_BAD_LEAD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_READY;
         partial_ff <= '0;
      end else if (accept) begin
         phase_ff   <= phase_in;
         partial_ff <= partial_in;
      end
   end

   // a bad lead byte always leads into discarding
   `U8_ASSERT(a_bad_lead_discard, (cmd_push && cmd.kind == CMD_BAD_LEAD) |=> (phase_ff == PH_DISCARD), "bad lead did not enter discard")

endmodule

>>> design/u8dec_queue.sv
// Short command queue between front end and back end.
// Depends on u8dec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8dec_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    wr_en,
   input  u8dec_pkg::cmd_type      wr_data,
   input  logic                    rd_en,
   output u8dec_pkg::cmd_type      rd_data,
   output u8dec_pkg::q_status_type status
);
   import u8dec_pkg::*;

   cmd_type           mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff, count_in;

   assign status.full  = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign rd_data      = mem_ff[rd_ptr_ff];

   always_comb begin
      unique case ({wr_en, rd_en})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (wr_en) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (rd_en) rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_ptr_ff] <= wr_data;
   end

   `U8_NEVER(a_no_overflow, wr_en && status.full, "write into full queue")
   `U8_NEVER(a_no_underflow, rd_en && status.empty, "read from empty queue")

endmodule

>>> design/u8dec_back.sv
// Back end: expands queued commands into code units behind an output register.
// Depends on u8dec_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8dec_back (
   input  logic                    clock,
   input  logic                    reset,
   input  u8dec_pkg::cmd_type      head,
   input  u8dec_pkg::q_status_type q_status,
   output logic                    q_rd,
   output logic [15:0]             rsp_code_unit,
   output logic                    rsp_end_of_string,
   output logic                    empty,
   input  logic                    pop
);
   import u8dec_pkg::*;

   logic              valid_ff, valid_in;
   logic [15:0]       unit_ff;
   logic              eos_ff;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              take;
   logic [15:0]       unit_sel;
   logic              eos_sel;
   logic              last_sel;

   // output slot frees up when empty or being drained this cycle
   assign take = (!valid_ff || pop) && !q_status.empty;

   always_comb begin
      unique case (head.kind)
         CMD_UNIT: begin
            unit_sel = head.unit;
            eos_sel  = head.eos;
            last_sel = 1'b1;
         end
         CMD_ELLIPSIS: begin
            unit_sel = UNIT_PERIOD;
            eos_sel  = 1'b0;
            last_sel = step_ff == ELLIPSIS_LAST_STEP;
         end
         CMD_BAD_LEAD: begin
            last_sel = step_ff == BAD_LEAD_LAST_STEP;
            unit_sel = last_sel ? UNIT_TERM : UNIT_QUESTION;
            eos_sel  = last_sel;
         end
         default: begin
            unit_sel = UNIT_TERM;
            eos_sel  = 1'b1;
            last_sel = 1'b1;
         end
      endcase
   end

   assign q_rd     = take && last_sel;
   assign valid_in = take || (valid_ff && !pop);
   assign step_in  = !take ? step_ff : (last_sel ? '0 : step_ff + STEP_W'(1));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         unit_ff <= unit_sel;
         eos_ff  <= eos_sel;
      end
   end

   assign rsp_code_unit     = unit_ff;
   assign rsp_end_of_string = eos_ff;
   assign empty             = !valid_ff;

   // a command partly expanded stays at the queue head
   `U8_ASSERT(a_step_has_head, (step_ff != '0) |-> !q_status.empty, "step without command")
   `U8_ASSERT(a_term_is_zero, (valid_ff && eos_ff) |-> (unit_ff == UNIT_TERM), "terminator not zero")

endmodule

>>> design/utf8_to_ucs2_stream_decoder.sv
// Path: a transferred byte's command is queued, then loaded into the output
// register on the rsp_ ports if the output slot is free. Throughput: one byte per
// cycle in unless full, one code unit per cycle out while popped; the back end's
// single output register limits output, so 0x85 (three units) and bad leads (two)
// draw down the 4-entry command queue; full rises only when it is exhausted.
// Reset: synchronous, active high; phase to ready, queue and output slot emptied.
module utf8_to_ucs2_stream_decoder (
   input  logic        clock,
   input  logic        reset,
   // byte input channel
   input  logic        push,
   input  logic [7:0]  req_in_byte,
   output logic        full,
   // code unit result channel
   output logic        empty,
   input  logic        pop,
   output logic [15:0] rsp_code_unit,
   output logic        rsp_end_of_string
);
   import u8dec_pkg::*;

   cmd_type      cmd_wr;
   cmd_type      cmd_head;
   logic         cmd_push;
   logic         cmd_rd;
   q_status_type q_status;

   // Input transfers stall only on a full command queue; bytes that make no
   // unit (lead bytes, discarded bytes) also wait for a free slot.
   assign full = q_status.full;

   // Front: phase tracking and classification of each byte into a command.
   u8dec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .req_in_byte (req_in_byte),
      .q_full      (q_status.full),
      .cmd_push    (cmd_push),
      .cmd         (cmd_wr)
   );

   // Decoupling queue: lets the front take bytes while the back expands
   // multi-unit commands or waits on pop.
   u8dec_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (cmd_push),
      .wr_data (cmd_wr),
      .rd_en   (cmd_rd),
      .rd_data (cmd_head),
      .status  (q_status)
   );

   // Back: one code unit per cycle into the output register, if its slot is free.
   u8dec_back u_back (
      .clock             (clock),
      .reset             (reset),
      .head              (cmd_head),
      .q_status          (q_status),
      .q_rd              (cmd_rd),
      .rsp_code_unit     (rsp_code_unit),
      .rsp_end_of_string (rsp_end_of_string),
      .empty             (empty),
      .pop               (pop)
   );

endmodule
